@@ hdl/pnpc_pkg.sv @@
// shared types and constants for the polyline near-plane clip unit
// no dependencies
package pnpc_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int CFG_IDX_BITS   = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_COEF_X   = 3'd0,
    CFG_COEF_Y   = 3'd1,
    CFG_COEF_Z   = 3'd2,
    CFG_OFFSET   = 3'd3,
    CFG_CLIP     = 3'd4
  } cfg_idx_e;

  // what the back end has to produce for one queued vertex
  typedef enum logic [1:0] {
    KIND_VERT,
    KIND_CROSS_OUT,
    KIND_CROSS_IN
  } kind_e;

  // front end sequencer
  typedef enum logic [2:0] {F_IDLE, F_MUL, F_ACC, F_SUM, F_CLS} fst_e;

  // back end sequencer
  typedef enum logic [2:0] {B_IDLE, B_DIV, B_MUL, B_ADD, B_EMITC, B_EMITV} bst_e;

  typedef struct packed {
    logic  valid;
    kind_e kind;
  } ent_ctl_t;

endpackage

@@ hdl/pnpc_fifo.sv @@
// small register queue, used between front and back and for results
// depends on nothing but its parameters
module pnpc_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  logic [DW-1:0] wdata_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic [DW-1:0] rdata_o,
  output logic          empty_o
);

  localparam int AB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CB = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [AB-1:0] wp_q, rp_q;
  logic [CB-1:0] cnt_q;
  logic          do_wr, do_rd;

  assign full_o  = (cnt_q == CB'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= (wp_q == AB'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_rd) begin
        rp_q <= (rp_q == AB'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + CB'(do_wr) - CB'(do_rd);
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CB'(DEPTH)) else $error("queue count overrun");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count lost a write");
  a_ptr_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> wp_q == rp_q) else $error("pointers disagree when empty");
`endif

endmodule

@@ hdl/pnpc_front.sv @@
// front end: depth dot product, saturation, front/back classification
// depends on pnpc_pkg
module pnpc_front import pnpc_pkg::*; #(
  parameter int W = COORD_BITS_DEF,
  parameter int F = FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  output logic         full_o,
  input  logic [W-1:0] pt_x_i,
  input  logic [W-1:0] pt_y_i,
  input  logic [W-1:0] pt_z_i,
  input  logic         first_i,
  input  logic         last_i,
  input  logic [W-1:0] coef_x_i,
  input  logic [W-1:0] coef_y_i,
  input  logic [W-1:0] coef_z_i,
  input  logic [W-1:0] offset_i,
  input  logic [W-1:0] clip_i,
  output ent_ctl_t     ent_o,
  input  logic         ent_ready_i,
  output logic [W-1:0] cur_x_o,
  output logic [W-1:0] cur_y_o,
  output logic [W-1:0] cur_z_o,
  output logic [W-1:0] prv_x_o,
  output logic [W-1:0] prv_y_o,
  output logic [W-1:0] prv_z_o,
  output logic [W:0]   un_o,
  output logic [W:0]   ud_o
);

  localparam int AW = 2 * W + 2;

  fst_e state_q, state_d;
  logic [W-1:0]          pt_q [3];
  logic [W-1:0]          prv_q [3];
  logic                  first_q, last_q;
  logic [1:0]            k_q, k_d;
  logic signed [2*W-1:0] prod_q;
  logic signed [AW-1:0]  acc_q, acc_d;
  logic signed [W-1:0]   dep_q, dep_d;
  logic signed [W-1:0]   prv_dep_q;
  logic                  prv_front_q;
  logic [W-1:0]          coef_sel;
  logic signed [AW-1:0]  sh, sum;
  logic signed [W:0]     num, den;
  logic                  front, need, done;
  kind_e                 kind;

  always_comb begin
    case (k_q)
      2'd0:    coef_sel = coef_x_i;
      2'd1:    coef_sel = coef_y_i;
      default: coef_sel = coef_z_i;
    endcase
  end

  // floor shift of the exact sum, then offset, then saturate
  assign sh  = acc_q >>> F;
  assign sum = sh + AW'($signed(offset_i));
  always_comb begin
    if (sum[AW-1:W-1] == '0 || sum[AW-1:W-1] == '1) begin
      dep_d = sum[W-1:0];
    end else if (sum[AW-1]) begin
      dep_d = {1'b1, {(W-1){1'b0}}};
    end else begin
      dep_d = {1'b0, {(W-1){1'b1}}};
    end
  end

  assign front = dep_q < $signed(clip_i);
  assign num   = (W+1)'(prv_dep_q) - (W+1)'($signed(clip_i));
  assign den   = (W+1)'(prv_dep_q) - (W+1)'(dep_q);
  assign un_o  = num[W] ? (W+1)'(-num) : (W+1)'(num);
  assign ud_o  = den[W] ? (W+1)'(-den) : (W+1)'(den);

  always_comb begin
    need = 1'b0;
    kind = KIND_VERT;
    if (first_q) begin
      need = last_q || front;
    end else if (prv_front_q && front) begin
      need = 1'b1;
    end else if (prv_front_q != front) begin
      need = 1'b1;
      kind = front ? KIND_CROSS_IN : KIND_CROSS_OUT;
    end
  end

  assign cur_x_o = pt_q[0];
  assign cur_y_o = pt_q[1];
  assign cur_z_o = pt_q[2];
  assign prv_x_o = prv_q[0];
  assign prv_y_o = prv_q[1];
  assign prv_z_o = prv_q[2];
  assign full_o  = (state_q != F_IDLE);
  assign done    = (state_q == F_CLS) && (!need || ent_ready_i);

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    acc_d       = acc_q;
    ent_o.valid = 1'b0;
    ent_o.kind  = kind;
    case (state_q)
      F_IDLE: begin
        k_d   = '0;
        acc_d = '0;
        if (push_i) state_d = F_MUL;
      end
      F_MUL: state_d = F_ACC;
      F_ACC: begin
        acc_d = acc_q + AW'(prod_q);
        k_d   = k_q + 1'b1;
        state_d = (k_q == 2'd2) ? F_SUM : F_MUL;
      end
      F_SUM: state_d = F_CLS;
      F_CLS: begin
        ent_o.valid = need;
        if (done) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      k_q         <= '0;
      prv_q[0]    <= '0;
      prv_q[1]    <= '0;
      prv_q[2]    <= '0;
      prv_dep_q   <= '0;
      prv_front_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (done) begin
        prv_q[0]    <= pt_q[0];
        prv_q[1]    <= pt_q[1];
        prv_q[2]    <= pt_q[2];
        prv_dep_q   <= dep_q;
        prv_front_q <= front;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    prod_q <= $signed(coef_sel) * $signed(pt_q[k_q]);
    if (state_q == F_SUM) dep_q <= dep_d;
    if (state_q == F_IDLE && push_i) begin
      pt_q[0] <= pt_x_i;
      pt_q[1] <= pt_y_i;
      pt_q[2] <= pt_z_i;
      first_q <= first_i;
      last_q  <= last_i;
    end
  end

endmodule

@@ hdl/pnpc_back.sv @@
// back end: serial divide for t, lerp of the crossing, result writes
// depends on pnpc_pkg
module pnpc_back import pnpc_pkg::*; #(
  parameter int W = COORD_BITS_DEF,
  parameter int F = FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         ent_empty_i,
  output logic         ent_rd_o,
  input  kind_e        kind_i,
  input  logic [W-1:0] cur_x_i,
  input  logic [W-1:0] cur_y_i,
  input  logic [W-1:0] cur_z_i,
  input  logic [W-1:0] prv_x_i,
  input  logic [W-1:0] prv_y_i,
  input  logic [W-1:0] prv_z_i,
  input  logic [W:0]   un_i,
  input  logic [W:0]   ud_i,
  output logic         res_wr_o,
  input  logic         res_full_i,
  output logic [W-1:0] res_x_o,
  output logic [W-1:0] res_y_o,
  output logic [W-1:0] res_z_o,
  output logic         res_end_o
);

  localparam int PW = W + F + 3;
  localparam int CB = $clog2(F + 2);

  bst_e state_q, state_d;
  kind_e               kind_q;
  logic [W-1:0]        cur_q [3];
  logic [W-1:0]        prv_q [3];
  logic [W-1:0]        crd_q [3];
  logic [W+1:0]        rem_q, rem_d;
  logic [W:0]          ud_q;
  logic [F:0]          t_q, t_d;
  logic [CB-1:0]       cnt_q, cnt_d;
  logic [1:0]          ax_q, ax_d;
  logic signed [PW-1:0] prod_q, rnd;
  logic signed [W:0]   diff;
  logic                ge;
  logic [W+1:0]        sub;

  assign ge   = rem_q >= (W+2)'(ud_q);
  assign sub  = ge ? rem_q - (W+2)'(ud_q) : rem_q;
  assign diff = (W+1)'($signed(cur_q[ax_q])) - (W+1)'($signed(prv_q[ax_q]));
  // round half up before the shift
  assign rnd  = (prod_q + (PW'(1) <<< (F - 1))) >>> F;

  always_comb begin
    state_d   = state_q;
    rem_d     = rem_q;
    t_d       = t_q;
    cnt_d     = cnt_q;
    ax_d      = ax_q;
    ent_rd_o  = 1'b0;
    res_wr_o  = 1'b0;
    res_x_o   = cur_q[0];
    res_y_o   = cur_q[1];
    res_z_o   = cur_q[2];
    res_end_o = 1'b1;
    case (state_q)
      B_IDLE: begin
        ent_rd_o = !ent_empty_i;
        rem_d    = (W+2)'(un_i);
        t_d      = '0;
        cnt_d    = '0;
        ax_d     = '0;
        if (!ent_empty_i) begin
          if (kind_i == KIND_VERT) state_d = B_EMITV;
          else if (ud_i == '0)     state_d = B_MUL;
          else                     state_d = B_DIV;
        end
      end
      B_DIV: begin
        t_d   = {t_q[F-1:0], ge};
        rem_d = {sub[W:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CB'(F)) state_d = B_MUL;
      end
      B_MUL: state_d = B_ADD;
      B_ADD: begin
        ax_d    = ax_q + 1'b1;
        state_d = (ax_q == 2'd2) ? B_EMITC : B_MUL;
      end
      B_EMITC: begin
        res_x_o   = crd_q[0];
        res_y_o   = crd_q[1];
        res_z_o   = crd_q[2];
        res_end_o = (kind_q == KIND_CROSS_OUT);
        res_wr_o  = 1'b1;
        if (!res_full_i) state_d = (kind_q == KIND_CROSS_IN) ? B_EMITV : B_IDLE;
      end
      B_EMITV: begin
        res_wr_o = 1'b1;
        if (!res_full_i) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cnt_q   <= '0;
      ax_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ax_q    <= ax_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    t_q    <= t_d;
    prod_q <= PW'(diff) * PW'($signed({1'b0, t_q}));
    if (state_q == B_ADD) crd_q[ax_q] <= prv_q[ax_q] + rnd[W-1:0];
    if (ent_rd_o) begin
      kind_q   <= kind_i;
      ud_q     <= ud_i;
      cur_q[0] <= cur_x_i;
      cur_q[1] <= cur_y_i;
      cur_q[2] <= cur_z_i;
      prv_q[0] <= prv_x_i;
      prv_q[1] <= prv_y_i;
      prv_q[2] <= prv_z_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_cross_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_EMITC) |-> kind_q != KIND_VERT) else $error("crossing for plain vertex");
  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_ADD) |-> t_q <= ((F+1)'(1) << F)) else $error("t above one");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_wr_o && res_full_i) |=> $stable(state_q)) else $error("result dropped");
`endif

endmodule

@@ hdl/polyline_near_plane_clip_unit.sv @@
// top level: configuration registers, front end, entry queue, back end, result queue
// depends on pnpc_pkg, pnpc_front, pnpc_back, pnpc_fifo
//
// Clips a stream of polyline vertices against a view-depth plane. A vertex is
// taken when push is high and full low; results leave through a two-entry queue
// (empty/pop), run_end marking the last result of a vertex. The front end takes
// no new vertex until done with the last (the accepting cycle, three products
// through one shared multiplier, then sum/saturate and classify, which waits for
// queue room) and hands it, if it yields output, to a two-entry queue. The back
// end reads an entry and writes a plain vertex; a crossing takes the entry read, F + 1
// divide steps (none if the depth difference is zero), a multiply and an add per
// axis for the lerp and one or two result writes. Plain vertices are paced by the
// front end, a run of crossings by the back end. Configuration writes are accepted
// in every cycle and should only be made while idle.
module polyline_near_plane_clip_unit import pnpc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [COORD_BITS-1:0]   point_x_i,
  input  logic [COORD_BITS-1:0]   point_y_i,
  input  logic [COORD_BITS-1:0]   point_z_i,
  input  logic                    line_first_i,
  input  logic                    line_last_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [COORD_BITS-1:0]   out_x_o,
  output logic [COORD_BITS-1:0]   out_y_o,
  output logic [COORD_BITS-1:0]   out_z_o,
  output logic                    run_end_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COORD_BITS-1:0]   cfg_data_i
);

  localparam int W  = COORD_BITS;
  localparam int EW = 2 + 6 * W + 2 * (W + 1);
  localparam int RW = 1 + 3 * W;

  logic [W-1:0] coef_x_q, coef_y_q, coef_z_q, offset_q, clip_q;
  ent_ctl_t     ent;
  logic         ent_full, ent_empty, ent_rd;
  logic [W-1:0] f_cx, f_cy, f_cz, f_px, f_py, f_pz;
  logic [W:0]   f_un, f_ud;
  logic [EW-1:0] ent_wdata, ent_rdata;
  kind_e        b_kind;
  logic         res_wr, res_full, res_end;
  logic [W-1:0] res_x, res_y, res_z;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_x_q <= '0;
      coef_y_q <= '0;
      coef_z_q <= W'(1) << FRAC_BITS;
      offset_q <= '0;
      clip_q   <= '0 - (W'(1) << (FRAC_BITS - 1));
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_COEF_X: coef_x_q <= cfg_data_i;
        CFG_COEF_Y: coef_y_q <= cfg_data_i;
        CFG_COEF_Z: coef_z_q <= cfg_data_i;
        CFG_OFFSET: offset_q <= cfg_data_i;
        CFG_CLIP:   clip_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pnpc_front #(.W(W), .F(FRAC_BITS)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full),
    .pt_x_i(point_x_i), .pt_y_i(point_y_i), .pt_z_i(point_z_i),
    .first_i(line_first_i), .last_i(line_last_i),
    .coef_x_i(coef_x_q), .coef_y_i(coef_y_q), .coef_z_i(coef_z_q),
    .offset_i(offset_q), .clip_i(clip_q),
    .ent_o(ent), .ent_ready_i(!ent_full),
    .cur_x_o(f_cx), .cur_y_o(f_cy), .cur_z_o(f_cz),
    .prv_x_o(f_px), .prv_y_o(f_py), .prv_z_o(f_pz),
    .un_o(f_un), .ud_o(f_ud)
  );

  assign ent_wdata = {ent.kind, f_cx, f_cy, f_cz, f_px, f_py, f_pz, f_un, f_ud};

  pnpc_fifo #(.DW(EW), .DEPTH(2)) u_ent_q (
    .clk_i, .rst_ni,
    .wr_i(ent.valid), .wdata_i(ent_wdata), .full_o(ent_full),
    .rd_i(ent_rd), .rdata_o(ent_rdata), .empty_o(ent_empty)
  );

  assign b_kind = kind_e'(ent_rdata[EW-1 -: 2]);

  pnpc_back #(.W(W), .F(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .ent_empty_i(ent_empty), .ent_rd_o(ent_rd), .kind_i(b_kind),
    .cur_x_i(ent_rdata[EW-3 -: W]),
    .cur_y_i(ent_rdata[EW-3-W -: W]),
    .cur_z_i(ent_rdata[EW-3-2*W -: W]),
    .prv_x_i(ent_rdata[EW-3-3*W -: W]),
    .prv_y_i(ent_rdata[EW-3-4*W -: W]),
    .prv_z_i(ent_rdata[EW-3-5*W -: W]),
    .un_i(ent_rdata[2*W+1 -: W+1]),
    .ud_i(ent_rdata[W:0]),
    .res_wr_o(res_wr), .res_full_i(res_full),
    .res_x_o(res_x), .res_y_o(res_y), .res_z_o(res_z), .res_end_o(res_end)
  );

  pnpc_fifo #(.DW(RW), .DEPTH(2)) u_res_q (
    .clk_i, .rst_ni,
    .wr_i(res_wr), .wdata_i({res_end, res_x, res_y, res_z}), .full_o(res_full),
    .rd_i(pop), .rdata_o({run_end_o, out_x_o, out_y_o, out_z_o}), .empty_o(empty)
  );

endmodule

@@ tb/tb.sv @@
// testbench for polyline_near_plane_clip_unit: directed and random polylines under several settings
// depends on pnpc_pkg and the clip unit; holds its own depth and crossing predictor
module tb;
  import pnpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               run_end;
  } vertex_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [31:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic line_first_i = 1'b0, line_last_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [31:0] out_x_o, out_y_o, out_z_o;
  logic run_end_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  polyline_near_plane_clip_unit DUT (.*);

  initial forever #10 clk_i = ~clk_i;

  // predictor copy of registers and vertex history
  logic signed [31:0] coef_x, coef_y, coef_z, depth_off, clip_z;
  logic signed [31:0] last_x, last_y, last_z, last_depth;
  logic               last_front;

  vertex_out_t expected_vertices[$];
  int fail_count = 0;
  int vertices_sent = 0;
  int results_seen = 0;
  int crossings_seen = 0;
  int push_idle_pct = 0;
  int pop_idle_pct = 0;
  int stall_cycles = 0;

  function automatic logic signed [31:0] view_depth(logic signed [31:0] x,
      logic signed [31:0] y, logic signed [31:0] z);
    logic signed [79:0] ax, ay, az, bx, by, bz, acc, off;
    ax = coef_x; ay = coef_y; az = coef_z;
    bx = x; by = y; bz = z; off = depth_off;
    acc = ax * bx + ay * by + az * bz;
    acc = (acc >>> 16) + off;
    if (acc > 80'sh7fffffff) return 32'sh7fffffff;
    if (acc < -80'sh80000000) return 32'sh80000000;
    return acc[31:0];
  endfunction

  function automatic logic signed [31:0] lerp_axis(logic signed [31:0] a,
      logic signed [31:0] b, longint t);
    longint w;
    w = (longint'(b) - longint'(a)) * t + (longint'(1) <<< 15);
    w = w >>> 16;
    return 32'(longint'(a) + w);
  endfunction

  function automatic void clip_vertex(logic signed [31:0] x, logic signed [31:0] y,
      logic signed [31:0] z, logic first, logic last);
    logic signed [31:0] d;
    logic front;
    longint num, den, un, ud, t;
    vertex_out_t v[$];
    vertex_out_t e;
    d = view_depth(x, y, z);
    front = d < clip_z;
    if (first) begin
      if (last || front) v.push_back('{x, y, z, 1'b0});
    end else if (last_front && front) begin
      v.push_back('{x, y, z, 1'b0});
    end else if (last_front != front) begin
      num = longint'(last_depth) - longint'(clip_z);
      den = longint'(last_depth) - longint'(d);
      un = num < 0 ? -num : num;
      ud = den < 0 ? -den : den;
      t = 0;
      if (ud != 0) begin
        for (int i = 0; i <= 16; i++) begin
          t = t << 1;
          if (un >= ud) begin
            un -= ud;
            t |= 1;
          end
          un = un << 1;
        end
      end
      e.x = lerp_axis(last_x, x, t);
      e.y = lerp_axis(last_y, y, t);
      e.z = lerp_axis(last_z, z, t);
      e.run_end = 1'b0;
      v.push_back(e);
      if (front) v.push_back('{x, y, z, 1'b0});
    end
    if (v.size() > 0) v[v.size()-1].run_end = 1'b1;
    foreach (v[i]) expected_vertices.push_back(v[i]);
    last_x = x; last_y = y; last_z = z; last_depth = d; last_front = front;
  endfunction

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
      logic first, logic last);
    if ($urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    push <= 1'b1;
    point_x_i <= x; point_y_i <= y; point_z_i <= z;
    line_first_i <= first; line_last_i <= last;
    do @(posedge clk_i); while (full);
    clip_vertex(x, y, z, first, last);
    vertices_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_COEF_X: coef_x = data;
      CFG_COEF_Y: coef_y = data;
      CFG_COEF_Z: coef_z = data;
      CFG_OFFSET: depth_off = data;
      CFG_CLIP:   clip_z = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
      logic [31:0] off, logic [31:0] clip);
    wait_drained();
    write_reg(CFG_COEF_X, cx);
    write_reg(CFG_COEF_Y, cy);
    write_reg(CFG_COEF_Z, cz);
    write_reg(CFG_OFFSET, off);
    write_reg(CFG_CLIP, clip);
  endtask

  // mostly small coordinates so depths land near the plane, sometimes anything
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0, 1:    return $urandom();
      2:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
    endcase
  endfunction

  task automatic test_defaults();
    // continuation straight after reset: back-to-front from the zeroed history
    send_vertex(0, 0, 32'hffff0000, 1'b0, 1'b0);
    send_vertex(32'h7fffffff, 32'h80000000, 32'hfffe0000, 1'b0, 1'b0);
    send_vertex(32'h80000000, 32'h7fffffff, 32'h00010000, 1'b0, 1'b0);  // front to back
    send_vertex(5, 7, 32'h00020000, 1'b0, 1'b0);                        // both behind
    send_vertex(3, 3, 32'hffff8000, 1'b0, 1'b1);                        // exactly on plane
    send_vertex(1, 2, 32'hffff0000, 1'b1, 1'b0);                        // start in front
    send_vertex(32'hffffffff, 0, 32'h80000000, 1'b0, 1'b1);
    send_vertex(9, 9, 32'h7fffffff, 1'b1, 1'b1);                        // lone point behind
    send_vertex(4, 4, 32'h80000000, 1'b1, 1'b1);                        // lone point in front
    send_vertex(6, 6, 32'h7fffffff, 1'b1, 1'b0);                        // start behind
    send_vertex(8, 8, 32'h80000000, 1'b0, 1'b1);
    send_vertex(2, 2, 32'h7fffffff, 1'b0, 1'b0);                        // after a closed line
    send_vertex(0, 0, 32'hffff7fff, 1'b0, 1'b1);
  endtask

  task automatic test_saturation();
    write_all(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    write_reg(CFG_UNUSED, 32'h12345678);
    send_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1, 1'b0);
    send_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0, 1'b0);
    send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, 1'b1);
    write_all(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send_vertex(32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 1'b0);
    send_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0, 1'b0);
    send_vertex(0, 0, 0, 1'b0, 1'b1);
  endtask

  task automatic test_random_lines(int items);
    int n, len;
    logic first, last;
    n = 0;
    while (n < items) begin
      len = $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
        first = (i == 0);
        last = (i == len - 1);
        if ($urandom_range(9) == 0) begin
          first = $urandom_range(1);
          last = $urandom_range(1);
        end
        send_vertex(pick_coord(), pick_coord(), pick_coord(), first, last);
        n++;
      end
    end
  endtask

  // random small depth row and plane, now and then full-range registers
  task automatic test_random_setting(int items);
    if ($urandom_range(3) == 0)
      write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    else
      write_all(32'($signed($urandom_range(4 << 16)) - (2 << 16)),
                32'($signed($urandom_range(4 << 16)) - (2 << 16)),
                32'($signed($urandom_range(4 << 16)) - (2 << 16)),
                32'($signed($urandom_range(2 << 16)) - (1 << 16)),
                32'($signed($urandom_range(2 << 16)) - (1 << 16)));
    test_random_lines(items);
  endtask

  // result side: compare each beat, then choose whether to pop next cycle
  always @(posedge clk_i) begin
    vertex_out_t e;
    if (rst_ni && pop && !empty) begin
      results_seen++;
      if (expected_vertices.size() == 0) begin
        $error("unexpected result x=%h y=%h z=%h", out_x_o, out_y_o, out_z_o);
        fail_count++;
      end else begin
        e = expected_vertices.pop_front();
        if (out_x_o !== e.x) begin
          $error("out_x expected %h actual %h", e.x, out_x_o); fail_count++;
        end
        if (out_y_o !== e.y) begin
          $error("out_y expected %h actual %h", e.y, out_y_o); fail_count++;
        end
        if (out_z_o !== e.z) begin
          $error("out_z expected %h actual %h", e.z, out_z_o); fail_count++;
        end
        if (run_end_o !== e.run_end) begin
          $error("run_end expected %b actual %b", e.run_end, run_end_o); fail_count++;
        end
        if (!e.run_end) crossings_seen++;
      end
    end
    pop <= ($urandom_range(99) >= pop_idle_pct);
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    coef_x = 0; coef_y = 0; coef_z = 32'sh00010000; depth_off = 0; clip_z = -32'sh8000;
    last_x = 0; last_y = 0; last_z = 0; last_depth = 0; last_front = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    push_idle_pct = 36; pop_idle_pct = 54;
    test_defaults();
    test_random_lines(250);
    test_saturation();
    test_random_setting(250);
    push_idle_pct = 54; pop_idle_pct = 36;
    test_random_setting(300);
    write_all(0, 0, 32'h00010000, 0, 0);
    test_random_lines(300);
    push_idle_pct = 0; pop_idle_pct = 0;
    test_random_setting(300);
    test_random_setting(300);
    wait_drained();
    $display("covered %0d vertices, %0d results of which %0d were crossings ahead of a vertex",
             vertices_sent, results_seen, crossings_seen);
    $display("settings: reset, saturating extremes, random rows and planes; three idling mixes");
    if (fail_count == 0 && expected_vertices.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
